// File: rtl/nearest_palette_color_defines.svh
// assertion macros shared by the checker
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

    // palette geometry
    localparam int SEARCHED_ENTRIES = 255;
    localparam int COLOR_W          = 8;
    localparam int ENTRY_W          = 3 * COLOR_W;
    localparam int CNT_W            = (SEARCHED_ENTRIES > 1) ? $clog2(SEARCHED_ENTRIES) : 1;
    localparam int IDX_OUT_W        = 8;
    localparam int CMP_W            = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;
    localparam int SQ_W             = 2 * COLOR_W;
    localparam int DIST_W           = 18;
    localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

    // one palette entry leaving the head of the ring
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [CNT_W-1:0] idx;
    } scan_t;

    // finished search
    typedef struct packed {
        logic              done;
        logic [CNT_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } result_t;

endpackage

// File: rtl/nearest_palette_color.sv
`timescale 1ns / 1ps

// Nearest palette color search. A transaction with req_type low stores one
// palette entry (busy stays low, no result); slots at or above the searched
// count, including transparent slot 255, are dropped. A transaction with
// req_type high searches all searched entries by squared RGB distance, lowest
// index winning ties. The palette sits in a ring of cells that rotates one
// entry per cycle past a single two-stage distance unit, so a query holds
// busy through the done cycle: done pulses for one cycle, and the next
// transaction may start the cycle after done. done cannot be held off:
// best_index and best_distance are valid only in the done cycle. Every
// entry must be written before the first query.

module nearest_palette_color
    import npc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [7:0]           entry_index,
    input  logic [COLOR_W-1:0]   red,
    input  logic [COLOR_W-1:0]   green,
    input  logic [COLOR_W-1:0]   blue,
    output logic                 done,
    output logic [IDX_OUT_W-1:0] best_index,
    output logic [DIST_W-1:0]    best_distance
);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               cnt_last;

    logic [COLOR_W-1:0] target_red_reg;
    logic [COLOR_W-1:0] target_green_reg;
    logic [COLOR_W-1:0] target_blue_reg;

    logic               accept;
    logic               wr_en;
    logic               query;
    logic               shift_en;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] ring [SEARCHED_ENTRIES];

    scan_t              scan;
    result_t            result;

    assign accept   = start && !busy;
    assign wr_en    = accept && (req_type == REQ_WRITE);
    assign query    = accept && (req_type == REQ_QUERY);
    assign wr_data  = {red, green, blue};
    assign cnt_last = (cnt_reg == CNT_W'(SEARCHED_ENTRIES - 1));

    // palette ring: cell 0 is the head, each cell takes from its upper neighbor
    for (genvar gi = 0; gi < SEARCHED_ENTRIES; gi++)
    begin : g_cell
        localparam int NEXT = (gi + 1) % SEARCHED_ENTRIES;

        npc_cell u_cell (
            .clk       (clk),
            .load      (wr_en && (CMP_W'(entry_index) == CMP_W'(gi))),
            .load_data (wr_data),
            .shift     (shift_en),
            .shift_in  (ring[NEXT]),
            .data      (ring[gi])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (result.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy     = 1'b1;
        shift_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                shift_en = 1'b1;
            end
            ST_WAIT:
            begin
                shift_en = 1'b0;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // entry counter, tags the entry at the head of the ring
    always_comb
    begin
        cnt_next = cnt_reg;
        if (query)
        begin
            cnt_next = '0;
        end
        else if (shift_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // query target
    always_ff @(posedge clk)
    begin
        if (query)
        begin
            target_red_reg   <= red;
            target_green_reg <= green;
            target_blue_reg  <= blue;
        end
    end

    assign scan.valid = shift_en;
    assign scan.last  = cnt_last;
    assign scan.idx   = cnt_reg;

    npc_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_in      (scan),
        .entry        (ring[0]),
        .target_red   (target_red_reg),
        .target_green (target_green_reg),
        .target_blue  (target_blue_reg),
        .result       (result)
    );

    assign done          = result.done;
    assign best_index    = IDX_OUT_W'(result.idx);
    assign best_distance = result.distance;

endmodule

// File: rtl/npc_cell.sv
`timescale 1ns / 1ps

module npc_cell
    import npc_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [ENTRY_W-1:0] load_data,
    input  logic               shift,
    input  logic [ENTRY_W-1:0] shift_in,
    output logic [ENTRY_W-1:0] data
);

    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;

    // direct write when idle, rotate toward the head during a search
    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/npc_dist.sv
`timescale 1ns / 1ps

module npc_dist
    import npc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_t              scan_in,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [COLOR_W-1:0] target_red,
    input  logic [COLOR_W-1:0] target_green,
    input  logic [COLOR_W-1:0] target_blue,
    output result_t            result
);

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    logic [COLOR_W-1:0] d_red;
    logic [COLOR_W-1:0] d_green;
    logic [COLOR_W-1:0] d_blue;

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [CNT_W-1:0]  s1_idx_reg;
    logic [SQ_W-1:0]   sq_red_reg;
    logic [SQ_W-1:0]   sq_green_reg;
    logic [SQ_W-1:0]   sq_blue_reg;

    logic [DIST_W-1:0] sum;
    logic              take;

    logic              done_reg;
    logic [CNT_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;

    // stage 1: per-channel differences and squares
    assign d_red   = abs_diff(entry[3*COLOR_W-1:2*COLOR_W], target_red);
    assign d_green = abs_diff(entry[2*COLOR_W-1:COLOR_W], target_green);
    assign d_blue  = abs_diff(entry[COLOR_W-1:0], target_blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg  <= scan_in.last;
        s1_idx_reg   <= scan_in.idx;
        sq_red_reg   <= SQ_W'(d_red) * SQ_W'(d_red);
        sq_green_reg <= SQ_W'(d_green) * SQ_W'(d_green);
        sq_blue_reg  <= SQ_W'(d_blue) * SQ_W'(d_blue);
    end

    // stage 2: sum and keep the strictly nearer entry, first entry always taken
    assign sum  = DIST_W'(sq_red_reg) + DIST_W'(sq_green_reg) + DIST_W'(sq_blue_reg);
    assign take = (s1_idx_reg == '0) || (sum < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && take)
        begin
            best_idx_reg  <= s1_idx_reg;
            best_dist_reg <= sum;
        end
    end

    assign result.done     = done_reg;
    assign result.idx      = best_idx_reg;
    assign result.distance = best_dist_reg;

endmodule

// File: rtl/npc_checker.sv
`timescale 1ns / 1ps

`include "nearest_palette_color_defines.svh"

module npc_checker
    import npc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 req_type,
    input logic                 done,
    input logic [DIST_W-1:0]    best_distance
);

    // an accepted query keeps the block busy
    `NPC_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (req_type == REQ_QUERY), busy, "query did not raise busy")

    // a palette write leaves the block free, with no result, in the next cycle
    `NPC_ASSERT_NEXT(a_write_free, clk, rst_n, start && !busy && (req_type == REQ_WRITE), !busy && !done, "palette write held the block")

    // a result ends the query: single-cycle strobe, then idle
    `NPC_ASSERT_NEXT(a_done_ends, clk, rst_n, done, !done && !busy, "result strobe not followed by idle")

    // result only inside a query and within the distance range
    `NPC_ASSERT_NOW(a_done_range, clk, rst_n, done, busy && (best_distance <= MAX_DIST), "result outside a query or out of range")

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .done          (done),
    .best_distance (best_distance)
);
